@@ design/multi_channel_timer_pool_macros.svh @@
// Assertion macros used by the timer pool datapath.
`ifndef MULTI_CHANNEL_TIMER_POOL_MACROS_SVH
`define MULTI_CHANNEL_TIMER_POOL_MACROS_SVH
`ifndef SYNTHESIS
`define MCTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define MCTP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define MCTP_ASSERT(lbl, prop, msg)
`define MCTP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/mctp_pkg.sv @@
// Types and constants of the timer pool.
`default_nettype none
package mctp_pkg;

  localparam int unsigned MaxReports = 16;
  localparam int unsigned ReportCntW = 5;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_DELETE = 3'd3,
    OP_TICK   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPARAM = 2'd1,
    ST_NOFREE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_CREATE,
    S_TICK_PREP,
    S_TICK_SCAN,
    S_TICK_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic inc_idx;
    logic cmd_exec;
    logic create_take;
    logic create_full;
    logic tick_step;
    logic tick_done;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_free;
    logic idx_last;
    logic out_free;
    logic tick_report;
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/mctp_ctrl.sv @@
// Sequencing state machine of the timer pool.
`default_nettype none
module mctp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [2:0]          op_i,
  output logic                     in_stall_o,
  input  wire mctp_pkg::dp_status_t sts_i,
  output mctp_pkg::ctrl_cmd_t      cmd_o
);
  import mctp_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_CREATE) begin
            state_d = S_CREATE;
          end else if (op_i == OP_TICK) begin
            state_d = S_TICK_PREP;
          end else begin
            state_d = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_CREATE: begin
        if ((sts_i.idx_free || sts_i.idx_last) && sts_i.out_free) state_d = S_IDLE;
      end
      S_TICK_PREP: state_d = S_TICK_SCAN;
      S_TICK_SCAN: begin
        if ((!sts_i.tick_report || sts_i.out_free) && sts_i.idx_last) begin
          state_d = S_TICK_DONE;
        end
      end
      S_TICK_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.capture = accept;
      S_CMD: cmd_o.cmd_exec = sts_i.out_free;
      S_CREATE: begin
        if (sts_i.idx_free) begin
          cmd_o.create_take = sts_i.out_free;
        end else if (sts_i.idx_last) begin
          cmd_o.create_full = sts_i.out_free;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_TICK_SCAN: cmd_o.tick_step = !sts_i.tick_report || sts_i.out_free;
      S_TICK_DONE: cmd_o.tick_done = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ design/mctp_datapath.sv @@
// Slot flags, counter memories, scan index and output register of the timer pool.
`default_nettype none
`include "multi_channel_timer_pool_macros.svh"
module mctp_datapath #(
  parameter int unsigned NumSlots = 16,
  parameter int unsigned IdxW     = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [2:0]           op_i,
  input  wire logic [3:0]           slot_i,
  input  wire logic [31:0]          duration_i,
  input  wire logic                 periodic_i,
  input  wire mctp_pkg::ctrl_cmd_t  cmd_i,
  output mctp_pkg::dp_status_t      sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                kind_o,
  output logic [1:0]                status_o,
  output logic [3:0]                event_slot_o,
  output logic                      last_o
);
  import mctp_pkg::*;

  // latched command word
  logic [2:0]  op_q;
  logic [3:0]  slot_q;
  logic [31:0] dur_q;
  logic        per_q;

  logic [IdxW-1:0]       idx_q;
  logic [ReportCntW-1:0] n_q;

  logic [NumSlots-1:0] alloc_q, alloc_d;
  logic [NumSlots-1:0] active_q, active_d;
  logic [NumSlots-1:0] per_flag_q, per_flag_d;

  logic [31:0] reload_mem [NumSlots];
  logic [31:0] count_mem  [NumSlots];
  logic [31:0] cnt_rd_q, rel_rd_q;

  logic            idx_last, out_free;
  logic [6:0]      slot_ext, idx_ext;
  logic [IdxW-1:0] sidx, rd_addr, cnt_waddr;
  logic            slot_ok, start_ok;
  logic            tick_act, hit, report;
  logic [31:0]     cnt_dec, cnt_wdata;
  logic            cnt_we, rel_we;

  logic        out_load;
  logic [1:0]  kind_d, status_d;
  logic [3:0]  eslot_d;
  logic        last_d;
  logic        out_valid_q;

  assign idx_last = (idx_q == IdxW'(NumSlots - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ext = {3'b000, slot_q};
  assign idx_ext  = 7'(idx_q);
  assign sidx     = slot_ext[IdxW-1:0];
  assign slot_ok  = (slot_ext < 7'(NumSlots)) && alloc_q[sidx];
  assign start_ok = slot_ok && (dur_q != 32'd0);

  // one tick step on slot idx_q
  assign tick_act = alloc_q[idx_q] && active_q[idx_q];
  assign cnt_dec  = (cnt_rd_q != 32'd0) ? (cnt_rd_q - 32'd1) : 32'd0;
  assign hit      = tick_act && (cnt_dec == 32'd0);
  assign report   = hit && (n_q < ReportCntW'(MaxReports));

  assign sts_o.idx_free    = !alloc_q[idx_q];
  assign sts_o.idx_last    = idx_last;
  assign sts_o.out_free    = out_free;
  assign sts_o.tick_report = report;

  // read port follows the scan; it runs one slot ahead on a step
  assign rd_addr = (cmd_i.tick_step && !idx_last) ? (idx_q + IdxW'(1)) : idx_q;

  always_comb begin
    rel_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = cnt_dec;
    if (cmd_i.cmd_exec && (op_q == OP_START) && start_ok) begin
      rel_we    = 1'b1;
      cnt_we    = 1'b1;
      cnt_waddr = sidx;
      cnt_wdata = dur_q;
    end else if (cmd_i.tick_step && tick_act) begin
      cnt_we    = 1'b1;
      cnt_wdata = (hit && per_flag_q[idx_q]) ? rel_rd_q : cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rel_we) reload_mem[sidx] <= dur_q;
    if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= count_mem[rd_addr];
    rel_rd_q <= reload_mem[rd_addr];
  end

  always_comb begin
    alloc_d    = alloc_q;
    active_d   = active_q;
    per_flag_d = per_flag_q;
    if (cmd_i.cmd_exec) begin
      if (op_q == OP_START && start_ok) begin
        active_d[sidx] = 1'b1;
      end else if ((op_q == OP_STOP || op_q == OP_DELETE) && slot_ok) begin
        active_d[sidx] = 1'b0;
        if (op_q == OP_DELETE) alloc_d[sidx] = 1'b0;
      end
    end
    if (cmd_i.create_take) begin
      alloc_d[idx_q]    = 1'b1;
      active_d[idx_q]   = 1'b0;
      per_flag_d[idx_q] = per_q;
    end
    if (cmd_i.tick_step && hit && !per_flag_q[idx_q]) begin
      active_d[idx_q] = 1'b0;
    end
  end

  always_comb begin
    out_load = 1'b0;
    kind_d   = KIND_REPLY;
    status_d = ST_OK;
    eslot_d  = 4'd0;
    last_d   = 1'b1;
    if (cmd_i.cmd_exec) begin
      out_load = 1'b1;
      case (op_q)
        OP_START:            status_d = start_ok ? ST_OK : ST_BADPARAM;
        OP_STOP, OP_DELETE:  status_d = slot_ok ? ST_OK : ST_BADPARAM;
        default:             status_d = ST_BADPARAM;
      endcase
    end else if (cmd_i.create_take) begin
      out_load = 1'b1;
      eslot_d  = idx_ext[3:0];
    end else if (cmd_i.create_full) begin
      out_load = 1'b1;
      status_d = ST_NOFREE;
    end else if (cmd_i.tick_step && report) begin
      out_load = 1'b1;
      kind_d   = KIND_EXPIRY;
      eslot_d  = idx_ext[3:0];
      last_d   = 1'b0;
    end else if (cmd_i.tick_done) begin
      out_load = 1'b1;
      kind_d   = KIND_TICK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q     <= '0;
      active_q    <= '0;
      per_flag_q  <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      alloc_q    <= alloc_d;
      active_q   <= active_d;
      per_flag_q <= per_flag_d;
      if (cmd_i.capture) begin
        idx_q <= '0;
        n_q   <= '0;
      end else begin
        if ((cmd_i.inc_idx || cmd_i.tick_step) && !idx_last) idx_q <= idx_q + IdxW'(1);
        if (cmd_i.tick_step && report) n_q <= n_q + ReportCntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      slot_q <= slot_i;
      dur_q  <= duration_i;
      per_q  <= periodic_i;
    end
    if (out_load) begin
      kind_o       <= kind_d;
      status_o     <= status_d;
      event_slot_o <= eslot_d;
      last_o       <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MCTP_ASSERT(a_out_no_overwrite, out_load |-> out_free, "output word overwritten while held")
  `MCTP_ASSERT_NEVER(a_active_alloc, (active_q & ~alloc_q) != '0, "active slot not allocated")
  `MCTP_ASSERT_NEVER(a_report_cap, n_q > ReportCntW'(MaxReports), "expiry report count overflow")
  `MCTP_ASSERT_NEVER(a_idx_range, idx_ext >= 7'(NumSlots), "scan index beyond pool")

endmodule
`default_nettype wire

@@ design/multi_channel_timer_pool.sv @@
// Sequence: a start/stop/delete command is captured in S_IDLE and its reply word is loaded in S_CMD;
//   a create checks one slot per cycle in S_CREATE; a tick passes S_TICK_PREP, S_TICK_SCAN, S_TICK_DONE.
// Throughput: a new command is taken only in S_IDLE; a tick scan steps through every slot, since the shared
//   counter memory port updates one slot per cycle. Output stalls hold each state that loads the output word.
// Reset: asynchronous, clears all slot flags, state machine and output valid; counter
//   memories are not cleared and are read only for slots started since.
`default_nettype none
module multi_channel_timer_pool #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] duration_i,
  input  wire logic        periodic_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [1:0]       status_o,
  output logic [3:0]       event_slot_o,
  output logic             last_o
);
  import mctp_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mctp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mctp_datapath #(
    .NumSlots (NUM_SLOTS),
    .IdxW     (IdxW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .slot_i       (slot_i),
    .duration_i   (duration_i),
    .periodic_i   (periodic_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .status_o     (status_o),
    .event_slot_o (event_slot_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
